>>> src/mecanum_wheel_speed_controller_macros.svh
// Assertion macros for the mecanum wheel speed controller.
// Uses clk and rst of the including module; define ASSERT_OFF to drop all checks.
`ifndef MECANUM_WHEEL_SPEED_CONTROLLER_MACROS_SVH
`define MECANUM_WHEEL_SPEED_CONTROLLER_MACROS_SVH
`ifndef ASSERT_OFF
// check disabled while rst is high
`define MWSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mwsc check failed");
// check active through reset
`define MWSC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mwsc check failed");
`else
`define MWSC_ASSERT(lbl, prop)
`define MWSC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> src/mwsc_pkg.sv
// Shared types and constants of the mecanum wheel speed controller.
// No dependencies.
package mwsc_pkg;

  localparam int WHEEL_COUNT = 4;
  localparam int LIM_W       = 15;
  localparam int DIV_QW      = LIM_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // per-wheel mix signs (bit k set means negate for wheel k) and front-lane mask
  localparam logic [WHEEL_COUNT-1:0] LANE_NEG_VX = 4'b1001;
  localparam logic [WHEEL_COUNT-1:0] LANE_NEG_VY = 4'b0011;
  localparam logic [WHEEL_COUNT-1:0] LANE_FRONT  = 4'b0011;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_LIM  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_FRONT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_REAR   = 3'd7;

  typedef struct packed {
    logic signed [15:0] cmd_vx;
    logic signed [15:0] cmd_vy;
    logic signed [15:0] cmd_wz;
    logic signed [15:0] meas_speed_0;
    logic signed [15:0] meas_speed_1;
    logic signed [15:0] meas_speed_2;
    logic signed [15:0] meas_speed_3;
  } in_t;

  typedef struct packed {
    logic signed [15:0] drive_current_0;
    logic signed [15:0] drive_current_1;
    logic signed [15:0] drive_current_2;
    logic signed [15:0] drive_current_3;
  } out_t;

  typedef struct packed {
    logic [15:0]        gain_p;
    logic [15:0]        gain_i;
    logic [15:0]        gain_d;
    logic [LIM_W-1:0]   integral_limit;
    logic [LIM_W-1:0]   output_limit;
    logic [LIM_W-1:0]   wheel_speed_limit;
    logic signed [15:0] rotate_gain_front;
    logic signed [15:0] rotate_gain_rear;
  } cfg_t;

  typedef struct packed {
    logic mix_en;
    logic sum_en;
    logic scale_en;
    logic div_load;
    logic div_step;
    logic err_en;
    logic prod_en;
    logic integ_en;
    logic total_en;
    logic drive_en;
  } lane_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MIX, S_SUM, S_MAX, S_SCALE, S_LOAD, S_DIV,
    S_ERR, S_PROD, S_INTEG, S_TOTAL, S_DRIVE, S_OUT
  } state_t;

endpackage

>>> src/mwsc_div.sv
// Restoring unsigned divider, one quotient bit per step.
// Depends on mwsc_pkg (quotient width); quotient must fit DIV_QW bits.
module mwsc_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 33
) (
  input  logic                         clk,
  input  logic                         load,
  input  logic                         step,
  input  logic [NUM_W-1:0]             num,
  input  logic [DEN_W-1:0]             den,
  output logic [mwsc_pkg::DIV_QW-1:0]  quo
);
  localparam int QW  = mwsc_pkg::DIV_QW;
  localparam int SH_W = DEN_W + QW - 1;

  logic [NUM_W-1:0] rem;
  logic [SH_W-1:0]  dsh;
  logic [NUM_W-1:0] dsh_ext;
  logic             fits;

  assign dsh_ext = NUM_W'(dsh);
  assign fits    = rem >= dsh_ext;

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= num;
      dsh <= {den, {(QW-1){1'b0}}};
      quo <= '0;
    end else if (step) begin
      if (fits) begin
        rem <= rem - dsh_ext;
      end
      quo <= {quo[QW-2:0], fits};
      dsh <= dsh >> 1;
    end
  end
endmodule

>>> src/mwsc_lane.sv
// One wheel lane: command mix, limit scaling through mwsc_div, positional PID.
// Depends on mwsc_pkg and mwsc_div.
module mwsc_lane #(
  parameter int FRAC_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  mwsc_pkg::lane_ctrl_t      ctrl,
  input  mwsc_pkg::cfg_t            cfg,
  input  logic signed [15:0]        vx,
  input  logic signed [15:0]        vy,
  input  logic signed [15:0]        wz,
  input  logic signed [15:0]        rot_gain,
  input  logic                      neg_vx,
  input  logic                      neg_vy,
  input  logic signed [15:0]        meas,
  input  logic [((18+FRAC_BITS > 32) ? 18+FRAC_BITS : 32):0] max_abs,
  input  logic                      scale_sel,
  output logic [((18+FRAC_BITS > 32) ? 18+FRAC_BITS : 32):0] full_abs,
  output logic signed [15:0]        drive
);
  localparam int F      = FRAC_BITS;
  localparam int MIX_W  = 18 + F;
  localparam int FULL_W = ((MIX_W > 32) ? MIX_W : 32) + 1;
  localparam int NUM_W  = FULL_W + mwsc_pkg::LIM_W;
  localparam int INT_W  = 16 + F;
  localparam int ISUM_W = ((INT_W > 34) ? INT_W : 34) + 1;
  localparam int SUM_W  = ((INT_W > 35) ? INT_W : 35) + 2;

  logic signed [17:0]       vx_e, vy_e, lin18;
  logic signed [MIX_W-1:0]  lin;
  logic signed [31:0]       gw;
  logic signed [FULL_W-1:0] full;
  logic signed [FULL_W-1:0] full_rnd;
  logic [NUM_W-1:0]         num;
  logic signed [15:0]       tgt_plain;
  logic [mwsc_pkg::DIV_QW-1:0] quo;
  logic signed [15:0]       target;
  logic signed [16:0]       err;
  logic signed [17:0]       prev;
  logic signed [17:0]       diff;
  logic signed [33:0]       pp, ip;
  logic signed [34:0]       dd;
  logic signed [INT_W-1:0]  integ;
  logic signed [ISUM_W-1:0] isum, ilim;
  logic signed [SUM_W-1:0]  total, olim, tclamp, trnd;

  // mix terms
  assign vx_e  = 18'(vx);
  assign vy_e  = 18'(vy);
  assign lin18 = (neg_vx ? -vx_e : vx_e) + (neg_vy ? -vy_e : vy_e);

  assign full_abs = full[FULL_W-1] ? FULL_W'(-full) : FULL_W'(full);
  assign full_rnd = full + (full[FULL_W-1] ? FULL_W'((1 << F) - 1) : FULL_W'(0));

  // signed target: scaled quotient or plain truncation
  always_comb begin
    if (scale_sel) begin
      target = full[FULL_W-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    end else begin
      target = tgt_plain;
    end
  end

  assign diff = 18'(err) - prev;
  assign ilim = ISUM_W'({cfg.integral_limit, {F{1'b0}}});
  assign isum = ISUM_W'(integ) + ISUM_W'(ip);
  assign olim = SUM_W'({cfg.output_limit, {F{1'b0}}});

  always_comb begin
    if (total > olim) begin
      tclamp = olim;
    end else if (total < -olim) begin
      tclamp = -olim;
    end else begin
      tclamp = total;
    end
  end
  assign trnd = tclamp + (tclamp[SUM_W-1] ? SUM_W'((1 << F) - 1) : SUM_W'(0));

  always_ff @(posedge clk) begin
    if (ctrl.mix_en) begin
      lin <= $signed({lin18, {F{1'b0}}});
      gw  <= rot_gain * wz;
    end
    if (ctrl.sum_en) begin
      full <= FULL_W'(lin) + FULL_W'(gw);
    end
    if (ctrl.scale_en) begin
      num       <= NUM_W'(full_abs) * NUM_W'(cfg.wheel_speed_limit);
      tgt_plain <= 16'(full_rnd >>> F);
    end
    if (ctrl.err_en) begin
      err <= 17'(target) - 17'(meas);
    end
    if (ctrl.prod_en) begin
      pp <= $signed({1'b0, cfg.gain_p}) * err;
      ip <= $signed({1'b0, cfg.gain_i}) * err;
      dd <= $signed({1'b0, cfg.gain_d}) * diff;
    end
    if (ctrl.total_en) begin
      total <= SUM_W'(pp) + SUM_W'(integ) + SUM_W'(dd);
    end
    if (ctrl.drive_en) begin
      drive <= 16'(trnd >>> F);
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
      prev  <= '0;
    end else begin
      if (ctrl.prod_en) begin
        prev <= 18'(err);
      end
      if (ctrl.integ_en) begin
        if (isum > ilim) begin
          integ <= INT_W'(ilim);
        end else if (isum < -ilim) begin
          integ <= INT_W'(-ilim);
        end else begin
          integ <= INT_W'(isum);
        end
      end
    end
  end

  mwsc_div #(.NUM_W(NUM_W), .DEN_W(FULL_W)) u_div (
    .clk  (clk),
    .load (ctrl.div_load),
    .step (ctrl.div_step),
    .num  (num),
    .den  (max_abs),
    .quo  (quo)
  );
endmodule

>>> src/mecanum_wheel_speed_controller.sv
// Mecanum wheel speed controller top level: config registers, sequencer,
// four wheel lanes (mwsc_lane) and the max-merge stage. Depends on mwsc_pkg.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one control tick
//   (chassis command plus four measured wheel speeds). Output channel
//   out_valid/out_ready/out_data returns the four drive currents.
//   Config port cfg_we/cfg_index/cfg_data writes one register per cycle;
//   write only while the block is idle.
// Sequence:
//   One transaction in flight. From input accept to out_valid the block runs
//   mix, sum, max merge, scale, divider load, one divider step per quotient
//   bit (one quotient bit a cycle), the PID steps error, products, integrator,
//   total and drive, and the output load. A new tick is accepted only in the
//   idle state; the divider loop takes most of the time.
// Reset:
//   rst clears integrators, previous errors, the sequencer and out_valid;
//   gains go to 0, limits to 32767.
// Stall:
//   The output register holds a finished result until taken; a new tick is
//   accepted meanwhile, and its result waits in the last stage if the
//   previous one has still not been taken.
`include "mecanum_wheel_speed_controller_macros.svh"
module mecanum_wheel_speed_controller #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  mwsc_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output mwsc_pkg::out_t                       out_data,
  input  logic                                 cfg_we,
  input  logic [mwsc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mwsc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  localparam int F      = FRAC_BITS;
  localparam int MIX_W  = 18 + F;
  localparam int FULL_W = ((MIX_W > 32) ? MIX_W : 32) + 1;
  localparam int NW     = mwsc_pkg::WHEEL_COUNT;
  localparam int QW     = mwsc_pkg::DIV_QW;
  localparam int CNT_W  = $clog2(QW);

  mwsc_pkg::state_t     state, state_next;
  mwsc_pkg::cfg_t       cfg;
  mwsc_pkg::in_t        item;
  mwsc_pkg::lane_ctrl_t ctrl;
  logic [CNT_W-1:0]     cnt;
  logic                 out_load;
  logic                 div_last;

  logic [FULL_W-1:0]    lane_abs [NW];
  logic signed [15:0]   lane_drv [NW];
  logic signed [15:0]   lane_meas [NW];
  logic [FULL_W-1:0]    max_comb;
  logic [FULL_W-1:0]    max_abs;
  logic                 scale_sel;

  assign div_last = cnt == CNT_W'(QW - 1);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p            <= '0;
      cfg.gain_i            <= '0;
      cfg.gain_d            <= '0;
      cfg.integral_limit    <= '1;
      cfg.output_limit      <= '1;
      cfg.wheel_speed_limit <= '1;
      cfg.rotate_gain_front <= '0;
      cfg.rotate_gain_rear  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mwsc_pkg::REG_GAIN_P:    cfg.gain_p            <= cfg_data;
        mwsc_pkg::REG_GAIN_I:    cfg.gain_i            <= cfg_data;
        mwsc_pkg::REG_GAIN_D:    cfg.gain_d            <= cfg_data;
        mwsc_pkg::REG_INT_LIMIT: cfg.integral_limit    <= cfg_data[mwsc_pkg::LIM_W-1:0];
        mwsc_pkg::REG_OUT_LIMIT: cfg.output_limit      <= cfg_data[mwsc_pkg::LIM_W-1:0];
        mwsc_pkg::REG_WHEEL_LIM: cfg.wheel_speed_limit <= cfg_data[mwsc_pkg::LIM_W-1:0];
        mwsc_pkg::REG_ROT_FRONT: cfg.rotate_gain_front <= $signed(cfg_data);
        mwsc_pkg::REG_ROT_REAR:  cfg.rotate_gain_rear  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      mwsc_pkg::S_IDLE:  if (in_valid) state_next = mwsc_pkg::S_MIX;
      mwsc_pkg::S_MIX:   state_next = mwsc_pkg::S_SUM;
      mwsc_pkg::S_SUM:   state_next = mwsc_pkg::S_MAX;
      mwsc_pkg::S_MAX:   state_next = mwsc_pkg::S_SCALE;
      mwsc_pkg::S_SCALE: state_next = mwsc_pkg::S_LOAD;
      mwsc_pkg::S_LOAD:  state_next = mwsc_pkg::S_DIV;
      mwsc_pkg::S_DIV:   if (div_last) state_next = mwsc_pkg::S_ERR;
      mwsc_pkg::S_ERR:   state_next = mwsc_pkg::S_PROD;
      mwsc_pkg::S_PROD:  state_next = mwsc_pkg::S_INTEG;
      mwsc_pkg::S_INTEG: state_next = mwsc_pkg::S_TOTAL;
      mwsc_pkg::S_TOTAL: state_next = mwsc_pkg::S_DRIVE;
      mwsc_pkg::S_DRIVE: state_next = mwsc_pkg::S_OUT;
      mwsc_pkg::S_OUT:   if (!out_valid || out_ready) state_next = mwsc_pkg::S_IDLE;
      default:           state_next = mwsc_pkg::S_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    ctrl     = '0;
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state)
      mwsc_pkg::S_IDLE:  in_ready      = 1'b1;
      mwsc_pkg::S_MIX:   ctrl.mix_en   = 1'b1;
      mwsc_pkg::S_SUM:   ctrl.sum_en   = 1'b1;
      mwsc_pkg::S_SCALE: ctrl.scale_en = 1'b1;
      mwsc_pkg::S_LOAD:  ctrl.div_load = 1'b1;
      mwsc_pkg::S_DIV:   ctrl.div_step = 1'b1;
      mwsc_pkg::S_ERR:   ctrl.err_en   = 1'b1;
      mwsc_pkg::S_PROD:  ctrl.prod_en  = 1'b1;
      mwsc_pkg::S_INTEG: ctrl.integ_en = 1'b1;
      mwsc_pkg::S_TOTAL: ctrl.total_en = 1'b1;
      mwsc_pkg::S_DRIVE: ctrl.drive_en = 1'b1;
      mwsc_pkg::S_OUT:   out_load      = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mwsc_pkg::S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.div_load) begin
        cnt <= '0;
      end else if (ctrl.div_step) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
    if (state == mwsc_pkg::S_MAX) begin
      max_abs <= max_comb;
    end
    if (ctrl.scale_en) begin
      scale_sel <= max_abs > FULL_W'({cfg.wheel_speed_limit, {F{1'b0}}});
    end
    if (out_load) begin
      out_data.drive_current_0 <= lane_drv[0];
      out_data.drive_current_1 <= lane_drv[1];
      out_data.drive_current_2 <= lane_drv[2];
      out_data.drive_current_3 <= lane_drv[3];
    end
  end

  // merge: largest absolute mix over the lanes
  always_comb begin
    max_comb = '0;
    for (int k = 0; k < NW; k++) begin
      if (lane_abs[k] > max_comb) begin
        max_comb = lane_abs[k];
      end
    end
  end

  assign lane_meas[0] = item.meas_speed_0;
  assign lane_meas[1] = item.meas_speed_1;
  assign lane_meas[2] = item.meas_speed_2;
  assign lane_meas[3] = item.meas_speed_3;

  for (genvar k = 0; k < NW; k++) begin : g_lane
    mwsc_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .cfg       (cfg),
      .vx        (item.cmd_vx),
      .vy        (item.cmd_vy),
      .wz        (item.cmd_wz),
      .rot_gain  (mwsc_pkg::LANE_FRONT[k] ? cfg.rotate_gain_front : cfg.rotate_gain_rear),
      .neg_vx    (mwsc_pkg::LANE_NEG_VX[k]),
      .neg_vy    (mwsc_pkg::LANE_NEG_VY[k]),
      .meas      (lane_meas[k]),
      .max_abs   (max_abs),
      .scale_sel (scale_sel),
      .full_abs  (lane_abs[k]),
      .drive     (lane_drv[k])
    );
  end

  // checks
  `MWSC_ASSERT(a_accept_starts_mix, (in_valid && in_ready) |=> (state == mwsc_pkg::S_MIX))
  `MWSC_ASSERT(a_div_runs_full, (state == mwsc_pkg::S_DIV && div_last) |=> (state == mwsc_pkg::S_ERR))
  `MWSC_ASSERT(a_out_from_last_stage, $rose(out_valid) |-> ($past(state) == mwsc_pkg::S_OUT))
  `MWSC_ASSERT(a_drive_clamped, out_valid |-> (out_data.drive_current_0 != 16'sh8000))
  `MWSC_ASSERT_ALWAYS(a_reset_drops_valid, rst |=> !out_valid)
endmodule
